// ===== hdl/cfpb_pkg.sv =====
// Shared constants, types and the CRC-8 byte update for the framed packet builder.
package cfpb_pkg;

  localparam int MAX_PAYLOAD = 128;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] MARK_A   = 8'hAA;
  localparam logic [7:0] MARK_B   = 8'h55;
  localparam logic [7:0] LEN_ADD  = 8'd5;

  // One accepted payload byte together with what the frame needs around it.
  typedef struct packed {
    logic        hdr;
    logic        trl;
    logic [7:0]  data;
    logic [7:0]  len;
    logic [7:0]  ftype;
    logic [31:0] stamp;
  } item_t;

  // Position in the output byte sequence of one item.
  typedef enum logic [12:0] {
    ST_MARK_A = 13'b0000000000001,
    ST_MARK_B = 13'b0000000000010,
    ST_LEN_HI = 13'b0000000000100,
    ST_LEN_LO = 13'b0000000001000,
    ST_STAMP3 = 13'b0000000010000,
    ST_STAMP2 = 13'b0000000100000,
    ST_STAMP1 = 13'b0000001000000,
    ST_STAMP0 = 13'b0000010000000,
    ST_TYPE   = 13'b0000100000000,
    ST_DATA   = 13'b0001000000000,
    ST_CRC    = 13'b0010000000000,
    ST_END_B  = 13'b0100000000000,
    ST_END_A  = 13'b1000000000000
  } step_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/cfpb_if.sv =====
// Valid/ready channel interfaces for payload input and framed byte output.
interface cfpb_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_len;
  logic [7:0]  frame_type;
  logic [31:0] stamp;

  modport source (output valid, output payload_byte, output payload_len,
                  output frame_type, output stamp, input ready);
  modport sink (input valid, input payload_byte, input payload_len,
                input frame_type, input stamp, output ready);
endinterface

interface cfpb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

// ===== hdl/crc8_framed_packet_builder_unit.sv =====
// Top level of the CRC-8 framed packet builder.
// An accepted item is held in the item register until its bytes enter the output register.
// Throughput: one output byte per cycle when out_ready is high; an item holds the sequencer
// until its bytes have moved on (1 for a pass-through byte, up to 13 for a one-byte frame).
// The single output byte port sets that figure; a new item is taken in the cycle its
// predecessor's last byte moves into the output register.
// Reset (rst_n low, synchronous) closes any open frame and clears the CRC and both channels.
module crc8_framed_packet_builder_unit #(
  parameter int MAX_PAYLOAD = cfpb_pkg::MAX_PAYLOAD
) (
  input logic        clk,
  input logic        rst_n,
  cfpb_in_if.sink    in_ch,
  cfpb_out_if.source out_ch
);

  cfpb_pkg::item_t in_item;
  logic            in_xfer;

  assign in_xfer = in_ch.valid && in_ch.ready;

  cfpb_framer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_framer (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_xfer),
    .payload_byte (in_ch.payload_byte),
    .payload_len  (in_ch.payload_len),
    .frame_type   (in_ch.frame_type),
    .stamp        (in_ch.stamp),
    .item         (in_item)
  );

  cfpb_serializer u_serializer (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_item       (in_item),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_byte      (out_ch.out_byte),
    .out_frame_end (out_ch.frame_end)
  );

  // The closing byte of every frame is the second trailer marker.
  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_end) |-> (out_ch.out_byte == cfpb_pkg::MARK_A))
    else $error("frame end flagged on a byte other than the trailer marker");

  // A frame opens with a length inside the supported range.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_item.hdr) |->
      ((in_item.len != 8'd0) && (in_item.len <= 8'(MAX_PAYLOAD))))
    else $error("frame opened with a length outside the supported range");

  // Only a one-byte frame can open and close on the same transfer.
  a_short_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_item.hdr && in_item.trl) |-> (in_item.len == 8'd1))
    else $error("frame closed on its first byte with a longer declared length");

endmodule

// ===== hdl/cfpb_framer.sv =====
// Frame tracking: decides header and trailer for each accepted payload byte.
module cfpb_framer #(
  parameter int MAX_PAYLOAD = cfpb_pkg::MAX_PAYLOAD
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      payload_byte,
  input  logic [7:0]      payload_len,
  input  logic [7:0]      frame_type,
  input  logic [31:0]     stamp,
  output cfpb_pkg::item_t item
);

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  logic       inside_r, inside_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] len_min, len_sat;

  always_comb begin
    // A zero length counts as one byte; longer frames saturate.
    len_min = (payload_len == 8'd0) ? 8'd1 : payload_len;
    len_sat = (len_min > MAX_LEN) ? MAX_LEN : len_min;

    if (!inside_r) begin
      left_nxt = len_sat - 8'd1;
    end else if (left_r != 8'd0) begin
      left_nxt = left_r - 8'd1;
    end else begin
      left_nxt = 8'd0;
    end
    inside_nxt = (left_nxt != 8'd0);

    item.hdr   = !inside_r;
    item.trl   = (left_nxt == 8'd0);
    item.data  = payload_byte;
    item.len   = len_sat;
    item.ftype = frame_type;
    item.stamp = stamp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      left_r   <= 8'd0;
    end else if (accept) begin
      inside_r <= inside_nxt;
      left_r   <= left_nxt;
    end
  end

endmodule

// ===== hdl/cfpb_serializer.sv =====
// Item register, byte sequencer with running CRC, and the output register.
module cfpb_serializer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cfpb_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_frame_end
);

  logic             item_valid_r;
  cfpb_pkg::item_t  item_r;
  cfpb_pkg::step_t  step_r, step_nxt;
  logic [7:0]       crc_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_end_r;

  logic             out_free, adv, last, load;
  logic [7:0]       cur_byte;
  logic [15:0]      total;

  assign total    = 16'(item_r.len) + 16'(cfpb_pkg::LEN_ADD);
  assign out_free = !out_valid_r || out_ready;
  assign adv      = item_valid_r && out_free;
  assign last     = ((step_r == cfpb_pkg::ST_DATA) && !item_r.trl) ||
                    (step_r == cfpb_pkg::ST_END_A);
  assign in_ready = !item_valid_r || (adv && last);
  assign load     = in_valid && in_ready;

  always_comb begin
    cur_byte = item_r.data;
    step_nxt = step_r;
    unique case (step_r)
      cfpb_pkg::ST_MARK_A: begin
        cur_byte = cfpb_pkg::MARK_A;
        step_nxt = cfpb_pkg::ST_MARK_B;
      end
      cfpb_pkg::ST_MARK_B: begin
        cur_byte = cfpb_pkg::MARK_B;
        step_nxt = cfpb_pkg::ST_LEN_HI;
      end
      cfpb_pkg::ST_LEN_HI: begin
        cur_byte = total[15:8];
        step_nxt = cfpb_pkg::ST_LEN_LO;
      end
      cfpb_pkg::ST_LEN_LO: begin
        cur_byte = total[7:0];
        step_nxt = cfpb_pkg::ST_STAMP3;
      end
      cfpb_pkg::ST_STAMP3: begin
        cur_byte = item_r.stamp[31:24];
        step_nxt = cfpb_pkg::ST_STAMP2;
      end
      cfpb_pkg::ST_STAMP2: begin
        cur_byte = item_r.stamp[23:16];
        step_nxt = cfpb_pkg::ST_STAMP1;
      end
      cfpb_pkg::ST_STAMP1: begin
        cur_byte = item_r.stamp[15:8];
        step_nxt = cfpb_pkg::ST_STAMP0;
      end
      cfpb_pkg::ST_STAMP0: begin
        cur_byte = item_r.stamp[7:0];
        step_nxt = cfpb_pkg::ST_TYPE;
      end
      cfpb_pkg::ST_TYPE: begin
        cur_byte = item_r.ftype;
        step_nxt = cfpb_pkg::ST_DATA;
      end
      cfpb_pkg::ST_DATA: begin
        cur_byte = item_r.data;
        step_nxt = cfpb_pkg::ST_CRC;
      end
      cfpb_pkg::ST_CRC: begin
        cur_byte = crc_r;
        step_nxt = cfpb_pkg::ST_END_B;
      end
      cfpb_pkg::ST_END_B: begin
        cur_byte = cfpb_pkg::MARK_B;
        step_nxt = cfpb_pkg::ST_END_A;
      end
      cfpb_pkg::ST_END_A: begin
        cur_byte = cfpb_pkg::MARK_A;
        step_nxt = cfpb_pkg::ST_END_A;
      end
      default: begin
        cur_byte = item_r.data;
        step_nxt = cfpb_pkg::ST_END_A;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      step_r       <= cfpb_pkg::ST_DATA;
    end else if (load) begin
      item_valid_r <= 1'b1;
      step_r       <= in_item.hdr ? cfpb_pkg::ST_MARK_A : cfpb_pkg::ST_DATA;
    end else if (adv && last) begin
      item_valid_r <= 1'b0;
    end else if (adv) begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  // The CRC follows stamp, type and data bytes into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= 8'd0;
    end else if (adv) begin
      case (step_r) inside
        cfpb_pkg::ST_STAMP3, cfpb_pkg::ST_STAMP2, cfpb_pkg::ST_STAMP1,
        cfpb_pkg::ST_STAMP0, cfpb_pkg::ST_TYPE, cfpb_pkg::ST_DATA: begin
          crc_r <= cfpb_pkg::crc8_feed(crc_r, cur_byte);
        end
        cfpb_pkg::ST_MARK_A, cfpb_pkg::ST_CRC: begin
          crc_r <= 8'd0;
        end
        default: begin
          crc_r <= crc_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= cur_byte;
      out_end_r  <= (step_r == cfpb_pkg::ST_END_A);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_end_r;

endmodule
